/* design/ssbm_pkg.sv */
// Shared constants, types and helper functions for the segment snap best-match block.
package ssbm_pkg;

	localparam int MAX_SEGMENTS = 256;
	localparam int NUM_REFS     = 4;
	localparam int COORD_BITS   = 16;

	localparam int CNT_W       = $clog2(MAX_SEGMENTS + 1);
	localparam int REF_W       = (NUM_REFS > 1) ? $clog2(NUM_REFS) : 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// register map: slots 0..3 are reference segments, then the two limits
	localparam int REF_SLOTS  = 4;
	localparam int REG_IDX_W  = 3;
	localparam int APB_ADDR_W = 6;
	localparam logic [REG_IDX_W-1:0] REG_DIST_LIMIT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COS_LIMIT  = 3'd5;

	localparam logic [32:0] DIST_LIMIT_RESET = 33'd3600;
	localparam logic [16:0] COS_LIMIT_RESET  = 17'd63560;

	typedef logic signed [15:0] coord_t;
	typedef logic signed [16:0] delta_t;

	typedef struct packed {
		coord_t      mid_x;
		coord_t      mid_y;
		delta_t      dx;
		delta_t      dy;
		logic [33:0] len_sq;
		logic        active;
		logic        last;
		logic [7:0]  seg_idx;
	} seg_entry_t;

	typedef struct packed {
		logic [NUM_REFS-1:0][63:0] ref_seg;
		logic [32:0]               dist_limit_sq;
		logic [16:0]               cos_sq_limit;
	} cfg_t;

	// keep the low COORD_BITS bits, sign-extended
	function automatic coord_t coord_sext(input logic [15:0] v);
		logic [15:0] t;
		t = v << (16 - COORD_BITS);
		return coord_t'($signed(t) >>> (16 - COORD_BITS));
	endfunction

	// (a + b) / 2 rounded toward zero
	function automatic coord_t midpoint(input coord_t a, input coord_t b);
		logic signed [16:0] s;
		s = 17'(a) + 17'(b);
		s = s + 17'(s[16]);
		return coord_t'(s >>> 1);
	endfunction

	// b - a at full width
	function automatic delta_t delta(input coord_t a, input coord_t b);
		return delta_t'(17'(b) - 17'(a));
	endfunction

endpackage

/* design/ssbm_front.sv */
// Input side: accepts segments, counts the batch and precomputes per-segment terms.
module ssbm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [63:0]          in_data,
	input  logic                 in_last,
	input  logic                 queue_full,
	output logic                 push,
	output ssbm_pkg::seg_entry_t push_entry
);
	import ssbm_pkg::*;

	logic [CNT_W-1:0] count_q;
	coord_t           x0, y0, x1, y1;
	delta_t           dx, dy;
	logic signed [33:0] sq_x, sq_y;
	logic             active;

	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;
	assign active   = (count_q < CNT_W'(MAX_SEGMENTS));

	always_comb begin
		x0   = coord_sext(in_data[15:0]);
		y0   = coord_sext(in_data[31:16]);
		x1   = coord_sext(in_data[47:32]);
		y1   = coord_sext(in_data[63:48]);
		dx   = delta(x0, x1);
		dy   = delta(y0, y1);
		sq_x = dx * dx;
		sq_y = dy * dy;
		push_entry.mid_x   = midpoint(x0, x1);
		push_entry.mid_y   = midpoint(y0, y1);
		push_entry.dx      = dx;
		push_entry.dy      = dy;
		push_entry.len_sq  = $unsigned(sq_x) + $unsigned(sq_y);
		push_entry.active  = active;
		push_entry.last    = in_last;
		push_entry.seg_idx = 8'(count_q);
	end

	// segments past the batch limit are not counted, only the last mark ends the batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			if (in_last) begin
				count_q <= '0;
			end else if (active) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

/* design/ssbm_queue.sv */
// Short queue of classified segments between the front and the compare pipeline.
module ssbm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ssbm_pkg::seg_entry_t push_data,
	output logic                 full,
	input  logic                 pop,
	output ssbm_pkg::seg_entry_t pop_data,
	output logic                 empty
);
	import ssbm_pkg::*;

	seg_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push, do_pop;

	assign full     = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* design/ssbm_back.sv */
// Compare pipeline: one reference per cycle unless held, running minimum, result register.
module ssbm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssbm_pkg::cfg_t       cfg,
	input  logic                 q_empty,
	input  ssbm_pkg::seg_entry_t q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_found,
	output logic                 out_have,
	output logic [7:0]           out_seg,
	output logic [1:0]           out_ref,
	output logic [32:0]          out_dist
);
	import ssbm_pkg::*;

	localparam logic [REF_W-1:0] REF_LAST = REF_W'(NUM_REFS - 1);

	logic             adv, iss_valid, iss_last_ref;
	logic [REF_W-1:0] ref_idx_q;
	logic [63:0]      rsel;
	coord_t           rx0, ry0, rx1, ry1;

	// stage 1: segment entry and reference terms
	logic             v_s1, last_s1;
	logic [REF_W-1:0] ref_s1;
	seg_entry_t       ent_s1;
	delta_t           rdx_s1, rdy_s1;
	coord_t           rmx_s1, rmy_s1;

	// stage 2: products
	logic               v_s2, last_s2, active_s2;
	logic [REF_W-1:0]   ref_s2;
	logic [7:0]         idx_s2;
	logic [33:0]        len1_s2;
	logic signed [33:0] dotx_s2, doty_s2, l2x_s2, l2y_s2, dsx_s2, dsy_s2;

	// stage 3: sums and early checks
	logic             v_s3, last_s3, pre_ok_s3;
	logic [REF_W-1:0] ref_s3;
	logic [7:0]       idx_s3;
	logic [33:0]      adot_s3, len1_s3, len2_s3, d_s3;

	// stage 4: squared dot and length product
	logic             v_s4, last_s4, pre_ok_s4;
	logic [REF_W-1:0] ref_s4;
	logic [7:0]       idx_s4;
	logic [33:0]      d_s4;
	logic [67:0]      sq_s4, l12_s4;

	// stage 5: left side of the angle test and the two halves of the right side
	logic             v_s5, last_s5, pre_ok_s5;
	logic [REF_W-1:0] ref_s5;
	logic [7:0]       idx_s5;
	logic [33:0]      d_s5;
	logic [83:0]      lhs_s5;
	logic [50:0]      rhs_hi_s5, rhs_lo_s5;

	// stage 6: compatibility verdict
	logic             v_s6, last_s6, match_s6;
	logic [REF_W-1:0] ref_s6;
	logic [7:0]       idx_s6;
	logic [33:0]      d_s6;

	// batch and held best pair
	logic             bf_q, held_valid_q, found_q, out_valid_q;
	logic [33:0]      bd_q, held_dist_q;
	logic [7:0]       bseg_q, held_seg_q;
	logic [REF_W-1:0] bref_q, held_ref_q;

	logic             take, nf;
	logic [33:0]      nd;
	logic [7:0]       nseg;
	logic [REF_W-1:0] nref;

	delta_t             e_dx, e_dy, ddx, ddy;
	logic signed [34:0] dot;
	logic [33:0]        adot, len2, dsum;

	// the whole pipeline holds while a result waits at the output
	assign adv          = !out_valid_q || out_ready;
	assign iss_valid    = !q_empty;
	assign iss_last_ref = (ref_idx_q == REF_LAST);
	assign q_pop        = iss_valid && adv && iss_last_ref;

	always_comb begin
		rsel = cfg.ref_seg[ref_idx_q];
		rx0  = coord_sext(rsel[15:0]);
		ry0  = coord_sext(rsel[31:16]);
		rx1  = coord_sext(rsel[47:32]);
		ry1  = coord_sext(rsel[63:48]);
	end

	always_comb begin
		e_dx = ent_s1.dx;
		e_dy = ent_s1.dy;
		ddx  = delta(rmx_s1, ent_s1.mid_x);
		ddy  = delta(rmy_s1, ent_s1.mid_y);
	end

	always_comb begin
		dot  = 35'(dotx_s2) + 35'(doty_s2);
		adot = (dot < 0) ? 34'(-dot) : 34'(dot);
		len2 = $unsigned(l2x_s2) + $unsigned(l2y_s2);
		dsum = $unsigned(dsx_s2) + $unsigned(dsy_s2);
	end

	// running minimum: lower distance wins, then lower reference; earlier segment on a full tie
	always_comb begin
		take = v_s6 && match_s6 &&
			(!bf_q || (d_s6 < bd_q) || ((d_s6 == bd_q) && (ref_s6 < bref_q)));
		nf   = bf_q || take;
		nd   = take ? d_s6 : bd_q;
		nseg = take ? idx_s6 : bseg_q;
		nref = take ? ref_s6 : bref_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_idx_q <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
		end else if (adv) begin
			if (iss_valid) begin
				ref_idx_q <= iss_last_ref ? '0 : ref_idx_q + 1'b1;
			end
			v_s1 <= iss_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1  <= q_data;
			ref_s1  <= ref_idx_q;
			last_s1 <= q_data.last && iss_last_ref;
			rdx_s1  <= delta(rx0, rx1);
			rdy_s1  <= delta(ry0, ry1);
			rmx_s1  <= midpoint(rx0, rx1);
			rmy_s1  <= midpoint(ry0, ry1);

			dotx_s2   <= e_dx * rdx_s1;
			doty_s2   <= e_dy * rdy_s1;
			l2x_s2    <= rdx_s1 * rdx_s1;
			l2y_s2    <= rdy_s1 * rdy_s1;
			dsx_s2    <= ddx * ddx;
			dsy_s2    <= ddy * ddy;
			len1_s2   <= ent_s1.len_sq;
			active_s2 <= ent_s1.active;
			last_s2   <= last_s1;
			ref_s2    <= ref_s1;
			idx_s2    <= ent_s1.seg_idx;

			adot_s3   <= adot;
			len1_s3   <= len1_s2;
			len2_s3   <= len2;
			d_s3      <= dsum;
			pre_ok_s3 <= active_s2 && (len1_s2 != '0) && (len2 != '0) &&
				(dsum <= {1'b0, cfg.dist_limit_sq});
			last_s3   <= last_s2;
			ref_s3    <= ref_s2;
			idx_s3    <= idx_s2;

			sq_s4     <= adot_s3 * adot_s3;
			l12_s4    <= len1_s3 * len2_s3;
			d_s4      <= d_s3;
			pre_ok_s4 <= pre_ok_s3;
			last_s4   <= last_s3;
			ref_s4    <= ref_s3;
			idx_s4    <= idx_s3;

			// split the limit product so each multiplier stays narrow
			lhs_s5    <= {sq_s4, 16'h0000};
			rhs_hi_s5 <= l12_s4[67:34] * cfg.cos_sq_limit;
			rhs_lo_s5 <= l12_s4[33:0] * cfg.cos_sq_limit;
			d_s5      <= d_s4;
			pre_ok_s5 <= pre_ok_s4;
			last_s5   <= last_s4;
			ref_s5    <= ref_s4;
			idx_s5    <= idx_s4;

			match_s6 <= pre_ok_s5 &&
				({1'b0, lhs_s5} >= ({rhs_hi_s5, 34'h0} + 85'(rhs_lo_s5)));
			d_s6     <= d_s5;
			last_s6  <= last_s5;
			ref_s6   <= ref_s5;
			idx_s6   <= idx_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_q         <= 1'b0;
			bd_q         <= '0;
			bseg_q       <= '0;
			bref_q       <= '0;
			held_valid_q <= 1'b0;
			held_dist_q  <= '0;
			held_seg_q   <= '0;
			held_ref_q   <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (adv && v_s6) begin
				if (last_s6) begin
					found_q      <= nf;
					held_valid_q <= held_valid_q || nf;
					if (nf) begin
						held_dist_q <= nd;
						held_seg_q  <= nseg;
						held_ref_q  <= nref;
					end
					bf_q   <= 1'b0;
					bd_q   <= '0;
					bseg_q <= '0;
					bref_q <= '0;
				end else begin
					bf_q   <= nf;
					bd_q   <= nd;
					bseg_q <= nseg;
					bref_q <= nref;
				end
			end
			if (adv && v_s6 && last_s6) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_found = found_q;
	assign out_have  = held_valid_q;
	assign out_seg   = held_seg_q;
	assign out_ref   = 2'(held_ref_q);
	assign out_dist  = held_dist_q[32:0];

endmodule

/* design/segment_snap_best_match_core.sv */
// Top level of the segment snap best-match block: register file, front, queue and back.
//
// Detected segments enter on the s_axis channel, one per transfer, with the four
// 16-bit endpoint coordinates in tdata and tlast marking the last segment of a batch.
// Each segment is compared with the reference segments held in the register file
// (written by the user over the APB port only while the block is idle; the block
// does not enforce this). On the transfer carrying tlast one result leaves on the
// m_axis channel: match flag for the batch, held-valid flag, and the held best
// segment index, reference index and squared midpoint distance. The shared compare
// pipeline takes one reference per cycle while no result waits at the output, and it
// takes a segment only after the last reference of the one before. A four-entry
// queue behind the front lets up to four segments be taken back to back before the
// input sees backpressure. With the back end idle, the last segment's references
// enter the compare pipeline in turn, and the last of them passes the remaining five
// stages and the result register. Reset clears the batch and the held pair, loads the
// register defaults and empties the queue and pipeline; there is no clearing pass.
// When the receiver holds m_axis_tready low the result register stays full and the
// compare pipeline holds; the queue keeps taking segments until it fills.
module segment_snap_best_match_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// segment input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // seg_x0, seg_y0, seg_x1, seg_y1 (16 bits each)
	input  logic        s_axis_tlast,  // last_segment
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // found_now, have_best, best_segment[7:0],
	                                   // best_reference[1:0], best_distance_sq[32:0], pad
);
	import ssbm_pkg::*;

	logic [NUM_REFS-1:0][63:0] ref_q;
	logic [32:0]               dist_limit_q;
	logic [16:0]               cos_limit_q;
	cfg_t                      cfg;

	logic [REG_IDX_W-1:0] reg_idx;
	logic [REF_W-1:0]     ref_sel;
	logic                 reg_wr, ref_hit;

	logic       push, q_full, q_empty, q_pop;
	seg_entry_t push_entry, q_data;

	logic        found, have;
	logic [7:0]  best_seg;
	logic [1:0]  best_ref;
	logic [32:0] best_dist;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign ref_sel = REF_W'(reg_idx);
	assign ref_hit = (reg_idx < REG_IDX_W'(REF_SLOTS)) && (32'(reg_idx) < NUM_REFS);
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q        <= '0;
			dist_limit_q <= DIST_LIMIT_RESET;
			cos_limit_q  <= COS_LIMIT_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_DIST_LIMIT: dist_limit_q <= pwdata[32:0];
				REG_COS_LIMIT:  cos_limit_q  <= pwdata[16:0];
				default: begin
					if (ref_hit) begin
						ref_q[ref_sel] <= pwdata;
					end
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_DIST_LIMIT: prdata = 64'(dist_limit_q);
			REG_COS_LIMIT:  prdata = 64'(cos_limit_q);
			default: begin
				if (ref_hit) begin
					prdata = ref_q[ref_sel];
				end
			end
		endcase
	end

	always_comb begin
		cfg.ref_seg       = ref_q;
		cfg.dist_limit_sq = dist_limit_q;
		cfg.cos_sq_limit  = cos_limit_q;
	end

	ssbm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_last    (s_axis_tlast),
		.queue_full (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ssbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	ssbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_found (found),
		.out_have  (have),
		.out_seg   (best_seg),
		.out_ref   (best_ref),
		.out_dist  (best_dist)
	);

	assign m_axis_tdata = {3'b000, best_dist, best_ref, best_seg, have, found};

endmodule
